>>> rtl/t2a_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// t2a_pkg
// Constants, status codes and base-word tables for the Thumb to ARM
// instruction translator.
// ----------------------------------------------------------------------------
package t2a_pkg;

  typedef logic [1:0]  status_t;
  typedef logic [1:0]  alu_kind_t;
  typedef logic [31:0] word_t;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_UNDEF  = 2'd1;
  localparam status_t ST_BRANCH = 2'd2;

  localparam logic [1:0] SIZE_THUMB = 2'd2;

  localparam word_t NOT_DONE      = 32'hDEAD_C0DE;
  localparam word_t SHIFT_BASE    = 32'hE1B0_0000;
  localparam word_t BX_BASE       = 32'hE12F_FF10;
  localparam word_t BLX_BASE      = 32'hE120_0030;
  localparam word_t HI_ADD_BASE   = 32'hE080_0000;
  localparam word_t HI_CMP_BASE   = 32'hE150_0000;
  localparam word_t HI_MOV_BASE   = 32'hE1A0_0000;
  localparam word_t LDR_PC_BASE   = 32'hE59F_0000;
  localparam word_t STRH_BASE     = 32'hE1C0_00B0;
  localparam word_t LDRH_BASE     = 32'hE1D0_00B0;
  localparam word_t STR_SP_BASE   = 32'hE58D_0000;
  localparam word_t LDR_SP_BASE   = 32'hE59D_0000;
  localparam word_t ADR_PC_BASE   = 32'hE28F_0F00;
  localparam word_t ADR_SP_BASE   = 32'hE28D_0F00;
  localparam word_t SP_ADD_BASE   = 32'hE28D_DF00;
  localparam word_t SP_SUB_BASE   = 32'hE24D_DF00;
  localparam word_t SWI_BASE      = 32'hEF00_0000;
  localparam word_t SWI_BKPT_MARK = 32'h0018_0000;
  localparam word_t SETEND_BASE   = 32'hF101_0000;
  localparam word_t CPS_BASE      = 32'hF108_0000;
  localparam word_t LDM_BASE      = 32'hE890_0000;
  localparam word_t STM_BASE      = 32'hE8A0_0000;

  localparam alu_kind_t ALU_NORMAL = 2'd0;
  localparam alu_kind_t ALU_SHIFT  = 2'd1;
  localparam alu_kind_t ALU_NEG    = 2'd2;
  localparam alu_kind_t ALU_MUL    = 2'd3;

  localparam word_t ADDSUB_TAB [4] = '{
    32'hE090_0000, 32'hE050_0000, 32'hE290_0000, 32'hE250_0000
  };
  localparam word_t IMM8_TAB [4] = '{
    32'hE3B0_0000, 32'hE350_0000, 32'hE290_0000, 32'hE250_0000
  };
  localparam word_t ALU_TAB [16] = '{
    32'hE010_0000, 32'hE030_0000, 32'hE1B0_0010, 32'hE1B0_0030,
    32'hE1B0_0050, 32'hE0B0_0000, 32'hE0D0_0000, 32'hE1B0_0070,
    32'hE110_0000, 32'hE270_0000, 32'hE150_0000, 32'hE170_0000,
    32'hE190_0000, 32'hE010_0090, 32'hE1D0_0000, 32'hE1F0_0000
  };
  localparam alu_kind_t ALU_KIND [16] = '{
    ALU_NORMAL, ALU_NORMAL, ALU_SHIFT,  ALU_SHIFT,
    ALU_SHIFT,  ALU_NORMAL, ALU_NORMAL, ALU_SHIFT,
    ALU_NORMAL, ALU_NEG,    ALU_NORMAL, ALU_NORMAL,
    ALU_NORMAL, ALU_MUL,    ALU_NORMAL, ALU_NORMAL
  };
  localparam word_t LDST_REG_TAB [8] = '{
    32'hE780_0000, 32'hE180_00B0, 32'hE7C0_0000, 32'hE190_00D0,
    32'hE790_0000, 32'hE190_00B0, 32'hE7D0_0000, 32'hE190_00F0
  };
  localparam word_t LDST_IMM_TAB [4] = '{
    32'hE580_0000, 32'hE590_0000, 32'hE5C0_0000, 32'hE5D0_0000
  };
  localparam word_t EXT_TAB [4] = '{
    32'hE6BF_0070, 32'hE6AF_0070, 32'hE6FF_0070, 32'hE6EF_0070
  };
  localparam word_t REV_TAB [4] = '{
    32'hE6BF_0F30, 32'hE6BF_0FB0, 32'h0000_0000, 32'hE6FF_0FB0
  };
  localparam word_t PUSHPOP_TAB [4] = '{
    32'hE92D_0000, 32'hE92D_4000, 32'hE8BD_0000, 32'hE8BD_8000
  };

  localparam logic [3:0] MISC_SP_ADJ = 4'h0;
  localparam logic [3:0] MISC_EXT    = 4'h2;
  localparam logic [3:0] MISC_CPS    = 4'h6;
  localparam logic [3:0] MISC_REV    = 4'hA;
  localparam logic [3:0] MISC_BKPT   = 4'hE;
  localparam logic [3:0] COND_UNDEF  = 4'hE;
  localparam logic [3:0] COND_SWI    = 4'hF;
  localparam logic [1:0] REV_UNDEF   = 2'd2;

  localparam logic [7:0] SWI_IMM_A = 8'h18;
  localparam logic [7:0] SWI_IMM_B = 8'hFE;

endpackage : t2a_pkg
`default_nettype wire

>>> rtl/thumb_to_arm_translator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thumb_to_arm_translator_unit
// Selects one Thumb halfword from a fetched word and rewrites it as a single
// equivalent ARM instruction word where it can, with a decode status.
//
//   channel | direction | ports                                    | handshake
//   in      | input     | fetch_word, fetch_address                | valid/ready
//   out     | output    | arm_word, decode_status, size_bytes      | valid/ready
//
// A request passes the halfword register, then the result register, at one
// request per cycle sustained while the result side does not stall.
// The rate is set by the single decode stage between those two registers.
// Synchronous active-low reset clears both valid flags.
// A stall on the result side holds the result; the input register keeps
// taking requests until it too is full.
// ----------------------------------------------------------------------------
module thumb_to_arm_translator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_fetch_word,
  input  wire logic [31:0] in_fetch_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_arm_word,
  output logic [1:0]       out_decode_status,
  output logic [1:0]       out_size_bytes
);

  logic                      s1_valid_r;
  logic [15:0]               half_r;
  logic [15:0]               half_nxt;
  logic                      out_valid_r;
  t2a_pkg::word_t            arm_r;
  t2a_pkg::word_t            arm_nxt;
  t2a_pkg::status_t          status_r;
  t2a_pkg::status_t          status_nxt;
  logic                      s1_adv;
  logic                      in_acc;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign half_nxt = in_fetch_address[1] ? in_fetch_word[31:16] : in_fetch_word[15:0];

  always_comb begin
    logic [31:0] t;
    logic [2:0]  r0;
    logic [2:0]  r3;
    logic [2:0]  r8;
    logic [3:0]  rd;
    logic [3:0]  rs;
    logic [3:0]  op;
    t          = {16'h0000, half_r};
    r0         = half_r[2:0];
    r3         = half_r[5:3];
    r8         = half_r[10:8];
    rd         = {half_r[7], half_r[2:0]};
    rs         = half_r[6:3];
    op         = half_r[9:6];
    arm_nxt    = t2a_pkg::NOT_DONE;
    status_nxt = t2a_pkg::ST_OK;
    case (half_r[15:11]) inside
      5'd0, 5'd1, 5'd2: begin
        arm_nxt = t2a_pkg::SHIFT_BASE | ((t & 32'h1800) >> 6) | ((t & 32'h07C0) << 1)
                | {29'd0, r3} | ({29'd0, r0} << 12);
      end
      5'd3: begin
        arm_nxt = t2a_pkg::ADDSUB_TAB[half_r[10:9]] | {29'd0, half_r[8:6]}
                | ({29'd0, r3} << 16) | ({29'd0, r0} << 12);
      end
      5'd4, 5'd5, 5'd6, 5'd7: begin
        arm_nxt = t2a_pkg::IMM8_TAB[half_r[12:11]] | (t & 32'hFF)
                | ({29'd0, r8} << 16) | ({29'd0, r8} << 12);
      end
      5'd8: begin
        if (!half_r[10]) begin
          arm_nxt = t2a_pkg::ALU_TAB[op];
          case (t2a_pkg::ALU_KIND[op])
            t2a_pkg::ALU_NORMAL: begin
              arm_nxt = arm_nxt | ({29'd0, r0} << 16) | ({29'd0, r0} << 12) | {29'd0, r3};
            end
            t2a_pkg::ALU_SHIFT: begin
              arm_nxt = arm_nxt | ({29'd0, r0} << 12) | {29'd0, r0} | ({29'd0, r3} << 8);
            end
            t2a_pkg::ALU_NEG: begin
              arm_nxt = arm_nxt | ({29'd0, r0} << 12) | ({29'd0, r3} << 16);
            end
            default: begin
              arm_nxt = arm_nxt | ({29'd0, r0} << 16) | ({29'd0, r0} << 8) | {29'd0, r3};
            end
          endcase
        end else begin
          case (half_r[9:8])
            2'd0: begin
              arm_nxt = t2a_pkg::HI_ADD_BASE | ({28'd0, rd} << 16) | ({28'd0, rd} << 12)
                      | {28'd0, rs};
            end
            2'd1: begin
              arm_nxt = t2a_pkg::HI_CMP_BASE | ({28'd0, rd} << 16) | {28'd0, rs};
            end
            2'd2: begin
              arm_nxt = t2a_pkg::HI_MOV_BASE | ({28'd0, rd} << 12) | {28'd0, rs};
            end
            default: begin
              arm_nxt = (half_r[7] ? t2a_pkg::BLX_BASE : t2a_pkg::BX_BASE) | {28'd0, rs};
            end
          endcase
        end
      end
      5'd9: begin
        arm_nxt = t2a_pkg::LDR_PC_BASE | ({29'd0, r8} << 12) | ((t & 32'hFF) << 2);
      end
      5'd10, 5'd11: begin
        arm_nxt = t2a_pkg::LDST_REG_TAB[half_r[11:9]] | ({29'd0, r0} << 12)
                | ({29'd0, r3} << 16) | {29'd0, half_r[8:6]};
      end
      5'd12, 5'd13, 5'd14, 5'd15: begin
        arm_nxt = t2a_pkg::LDST_IMM_TAB[half_r[12:11]] | ({29'd0, r0} << 12)
                | ({29'd0, r3} << 16)
                | (half_r[12] ? ((t & 32'h07C0) >> 6) : ((t & 32'h07C0) >> 4));
      end
      5'd16, 5'd17: begin
        arm_nxt = (half_r[11] ? t2a_pkg::LDRH_BASE : t2a_pkg::STRH_BASE)
                | ({29'd0, r0} << 12) | ({29'd0, r3} << 16)
                | ((t & 32'h01C0) >> 5) | ((t & 32'h0600) >> 1);
      end
      5'd18, 5'd19: begin
        arm_nxt = (half_r[11] ? t2a_pkg::LDR_SP_BASE : t2a_pkg::STR_SP_BASE)
                | ({29'd0, r8} << 12) | ((t & 32'hFF) << 2);
      end
      5'd20, 5'd21: begin
        arm_nxt = (half_r[11] ? t2a_pkg::ADR_SP_BASE : t2a_pkg::ADR_PC_BASE)
                | ({29'd0, r8} << 12) | (t & 32'hFF);
      end
      5'd22, 5'd23: begin
        case (half_r[11:8])
          t2a_pkg::MISC_SP_ADJ: begin
            arm_nxt = (half_r[7] ? t2a_pkg::SP_SUB_BASE : t2a_pkg::SP_ADD_BASE) | (t & 32'h7F);
          end
          t2a_pkg::MISC_BKPT: begin
            arm_nxt = t2a_pkg::SWI_BASE | {28'd0, half_r[3:0]} | ({28'd0, half_r[7:4]} << 8);
          end
          t2a_pkg::MISC_EXT: begin
            arm_nxt = t2a_pkg::EXT_TAB[half_r[7:6]] | ({29'd0, r0} << 12) | {29'd0, r3};
          end
          t2a_pkg::MISC_CPS: begin
            if (!half_r[5]) begin
              arm_nxt = t2a_pkg::SETEND_BASE | ({31'd0, half_r[3]} << 9);
            end else begin
              arm_nxt = t2a_pkg::CPS_BASE | ({31'd0, half_r[0]} << 6)
                      | ({31'd0, half_r[1]} << 7) | ({31'd0, half_r[2]} << 8)
                      | ({31'd0, half_r[4]} << 18);
            end
          end
          t2a_pkg::MISC_REV: begin
            if (half_r[7:6] == t2a_pkg::REV_UNDEF) begin
              status_nxt = t2a_pkg::ST_UNDEF;
            end else begin
              arm_nxt = t2a_pkg::REV_TAB[half_r[7:6]] | ({29'd0, r0} << 12) | {29'd0, r3};
            end
          end
          default: begin
            arm_nxt = t2a_pkg::PUSHPOP_TAB[{half_r[11], half_r[8]}] | (t & 32'hFF);
          end
        endcase
      end
      5'd24, 5'd25: begin
        if (half_r[11]) begin
          arm_nxt = t2a_pkg::LDM_BASE | ({29'd0, r8} << 16) | (t & 32'hFF)
                  | ({31'd0, !half_r[r8]} << 21);
        end else begin
          arm_nxt = t2a_pkg::STM_BASE | ({29'd0, r8} << 16) | (t & 32'hFF);
        end
      end
      5'd26, 5'd27: begin
        if (half_r[11:8] == t2a_pkg::COND_SWI) begin
          if (half_r[7:0] == t2a_pkg::SWI_IMM_A || half_r[7:0] == t2a_pkg::SWI_IMM_B) begin
            arm_nxt = t2a_pkg::SWI_BASE | t2a_pkg::SWI_BKPT_MARK;
          end else begin
            arm_nxt = t2a_pkg::SWI_BASE | (t & 32'hFF);
          end
        end else if (half_r[11:8] == t2a_pkg::COND_UNDEF) begin
          status_nxt = t2a_pkg::ST_UNDEF;
        end else begin
          status_nxt = t2a_pkg::ST_BRANCH;
        end
      end
      5'd29: begin
        status_nxt = half_r[0] ? t2a_pkg::ST_UNDEF : t2a_pkg::ST_BRANCH;
      end
      default: begin
        status_nxt = t2a_pkg::ST_BRANCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (!out_valid_r || out_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      half_r <= half_nxt;
    end
    if (s1_adv) begin
      arm_r    <= arm_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_arm_word      = arm_r;
  assign out_decode_status = status_r;
  assign out_size_bytes    = t2a_pkg::SIZE_THUMB;

  a_in_lands : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted request did not reach the decode register");

  a_stage_moves : assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("decoded request did not reach the result register");

  a_status_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (status_r == t2a_pkg::ST_OK || status_r == t2a_pkg::ST_UNDEF
                     || status_r == t2a_pkg::ST_BRANCH))
    else $error("result carries an unknown status code");

  a_untranslated_word : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != t2a_pkg::ST_OK) |-> (arm_r == t2a_pkg::NOT_DONE))
    else $error("untranslated result carries a word");

endmodule : thumb_to_arm_translator_unit
`default_nettype wire
